/* sv/ilb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilb_pkg
// Shared types and defaults for the indexed list buffer: request codes,
// status codes and the per-cycle update flags broadcast to the cell chain.
// ----------------------------------------------------------------------------
package ilb_pkg;

    // default geometry
    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 32;

    // request codes
    typedef enum logic [2:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_INSERT = 3'd4,
        OP_DELETE = 3'd5
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // update flags broadcast to every cell, at most one set per beat
    typedef struct packed {
        logic do_push;
        logic do_write;
        logic do_insert;
        logic do_delete;
    } cell_ctl_t;

endpackage

/* sv/ilb_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilb_cell
// One list entry. Holds a word, loads the request word, takes its lower
// neighbor's word on insert or its upper neighbor's word on delete.
// ----------------------------------------------------------------------------
module ilb_cell
    import ilb_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CNT_W     = 7
)
(
    input  logic                 clk,
    input  cell_ctl_t            ctl,
    input  logic [CNT_W-1:0]     pos,
    input  logic [CNT_W-1:0]     fill,
    input  logic [CNT_W-1:0]     rd_idx,
    input  logic [WORD_BITS-1:0] new_word,
    input  logic [WORD_BITS-1:0] prev_word,
    input  logic [WORD_BITS-1:0] next_word,
    output logic [WORD_BITS-1:0] word,
    output logic [WORD_BITS-1:0] sel_word
);

    localparam logic [CNT_W-1:0] MY_IDX  = CNT_W'(IDX);
    localparam logic [CNT_W:0]   MY_IDX1 = (CNT_W + 1)'(IDX + 1);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 at_pos;

    assign at_pos = (MY_IDX == pos);

    // pick the word this entry holds after the beat
    always_comb
    begin
        word_next = word_reg;
        if (ctl.do_push && (MY_IDX == fill))
        begin
            word_next = new_word;
        end
        else if (ctl.do_write && at_pos)
        begin
            word_next = new_word;
        end
        else if (ctl.do_insert)
        begin
            if (at_pos)
                word_next = new_word;
            else if ((MY_IDX > pos) && (MY_IDX <= fill))
                word_next = prev_word;
        end
        else if (ctl.do_delete)
        begin
            if ((MY_IDX >= pos) && (MY_IDX1 < {1'b0, fill}))
                word_next = next_word;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    // masked readout, or-combined at the top level
    assign sel_word = (MY_IDX == rd_idx) ? word_reg : '0;

endmodule

/* sv/indexed_list_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_buffer
// Ordered list of signed words with a fill count: push, pop, read, write,
// insert and delete, one result beat per request beat.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  request   in_valid / in_ready     kind, position, write_value
//  result    out_valid / out_ready   read_value, status, fill_level
//
//  the chain of entry cells shifts all later entries by one place in the
//  cycle a request is taken, so a new request can be taken each cycle
//  while the result register does not hold it back.
//  the result is held in an output register; a request is taken while that
//  register is empty or being drained in the same cycle.
//  reset clears the fill count and the result valid; entry words are not
//  cleared and are only read below the fill count.
// ----------------------------------------------------------------------------
module indexed_list_buffer
    import ilb_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int CNT_W     = $clog2(CAPACITY + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  kind,
    input  logic [CNT_W-1:0]            position,
    input  logic signed [WORD_BITS-1:0] write_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [WORD_BITS-1:0] read_value,
    output logic [1:0]                  status,
    output logic [CNT_W-1:0]            fill_level
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic                 out_valid_reg;
    logic [WORD_BITS-1:0] value_reg;
    logic [WORD_BITS-1:0] value_next;
    status_t              status_reg;
    status_t              status_next;
    logic [CNT_W-1:0]     level_reg;

    logic                 accept;
    logic                 use_word;
    cell_ctl_t            ctl;
    cell_ctl_t            ctl_gated;
    logic [CNT_W-1:0]     rd_idx;
    logic [WORD_BITS-1:0] rd_word;

    logic [WORD_BITS-1:0] cell_word [CAPACITY];
    logic [WORD_BITS-1:0] cell_sel  [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // request decode: status, fill update and cell flags
    always_comb
    begin
        ctl         = '0;
        fill_next   = fill_reg;
        status_next = ST_OK;
        use_word    = 1'b0;
        rd_idx      = position;
        case (kind)
            OP_PUSH:
            begin
                if (fill_reg >= CAP_CNT)
                    status_next = ST_FULL;
                else
                begin
                    ctl.do_push = 1'b1;
                    fill_next   = fill_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                rd_idx = fill_reg - 1'b1;
                if (fill_reg == '0)
                    status_next = ST_EMPTY;
                else
                begin
                    use_word  = 1'b1;
                    fill_next = fill_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if (position >= fill_reg)
                    status_next = ST_RANGE;
                else
                    use_word = 1'b1;
            end
            OP_WRITE:
            begin
                if (position >= fill_reg)
                    status_next = ST_RANGE;
                else
                    ctl.do_write = 1'b1;
            end
            OP_INSERT:
            begin
                if (position > fill_reg)
                    status_next = ST_RANGE;
                else if (fill_reg >= CAP_CNT)
                    status_next = ST_FULL;
                else
                begin
                    ctl.do_insert = 1'b1;
                    fill_next     = fill_reg + 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (fill_reg == '0)
                    status_next = ST_EMPTY;
                else if (position >= fill_reg)
                    status_next = ST_RANGE;
                else
                begin
                    ctl.do_delete = 1'b1;
                    use_word      = 1'b1;
                    fill_next     = fill_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign ctl_gated = accept ? ctl : '0;

    // combine the masked cell readouts
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_word = rd_word | cell_sel[i];
        end
    end

    // result word: taken entry, -1 on error, zero otherwise
    always_comb
    begin
        if (status_next != ST_OK)
            value_next = '1;
        else if (use_word)
            value_next = rd_word;
        else
            value_next = '0;
    end

    // chain of entry cells
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [WORD_BITS-1:0] prev_w;
        logic [WORD_BITS-1:0] next_w;

        if (g == 0)
        begin : g_first
            assign prev_w = '0;
        end
        else
        begin : g_prev
            assign prev_w = cell_word[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign next_w = '0;
        end
        else
        begin : g_next
            assign next_w = cell_word[g+1];
        end

        ilb_cell #(
            .IDX       (g),
            .WORD_BITS (WORD_BITS),
            .CNT_W     (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl_gated),
            .pos       (position),
            .fill      (fill_reg),
            .rd_idx    (rd_idx),
            .new_word  (write_value),
            .prev_word (prev_w),
            .next_word (next_w),
            .word      (cell_word[g]),
            .sel_word  (cell_sel[g])
        );
    end

    // fill count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg      <= fill_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
            level_reg  <= fill_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = value_reg;
    assign status     = status_reg;
    assign fill_level = level_reg;

endmodule

/* verif/indexed_list_buffer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_buffer_tb
// Self-checking bench for the indexed list buffer. A short table of directed
// requests covers the empty list, the word extremes, every request kind and
// the range errors. Random episodes follow: fill to full, drain to empty,
// mixed traffic and read/write bursts, all with bursty idling on both sides.
// Each request beat is run through a local list model, and each result beat
// is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module indexed_list_buffer_tb;
    import ilb_pkg::*;

    localparam int CAP          = CAPACITY_DEF;
    localparam int IDX_W        = $clog2(CAP);
    localparam int RANDOM_ITEMS = 1600;
    localparam int TAIL_ITEMS   = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;
    localparam int DIR_ROWS     = 24;
    localparam int TOTAL_ITEMS  = DIR_ROWS + RANDOM_ITEMS;

    // list capacity as a fill level
    localparam logic [6:0] CAP_LEVEL = 7'(CAP);

    // request kinds with no operation behind them
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // error word returned on every refused request
    localparam logic signed [31:0] ERR_WORD = '1;

    typedef struct packed {
        logic signed [31:0] value;
        status_t            st;
        logic [6:0]         level;
    } list_result_t;

    typedef struct packed {
        logic [2:0]   op;
        logic [6:0]   pos;
        logic [31:0]  word;
        bit           typed;
        list_result_t want;
    } stim_row_t;

    // ports
    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic [2:0]               kind        = '0;
    logic [6:0]               position    = '0;
    logic signed [31:0]       write_value = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic signed [31:0]       read_value;
    logic [1:0]               status;
    logic [6:0]               fill_level;

    // list model state and bookkeeping
    logic signed [31:0]       list_words [CAP];
    logic [6:0]               list_count = '0;
    list_result_t             expected_results [$];
    list_result_t             oldest_result;
    int                       mismatch_count = 0;
    int                       items_sent     = 0;
    int                       cycle_count    = 0;
    bit                       idle_on        = 1'b1;

    // directed requests; typed rows carry a result that reads off at a glance
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{OP_POP,    7'd0,   32'd0,          1'b1, '{ERR_WORD, ST_EMPTY, 7'd0}},
        '{OP_DELETE, 7'd0,   32'd0,          1'b1, '{ERR_WORD, ST_EMPTY, 7'd0}},
        '{OP_READ,   7'd0,   32'd0,          1'b1, '{ERR_WORD, ST_RANGE, 7'd0}},
        '{OP_WRITE,  7'd0,   32'd5,          1'b1, '{ERR_WORD, ST_RANGE, 7'd0}},
        '{OP_INSERT, 7'd1,   32'd5,          1'b1, '{ERR_WORD, ST_RANGE, 7'd0}},
        '{KIND_SPARE_HI, 7'd127, 32'hffffffff, 1'b1, '{32'd0, ST_OK, 7'd0}},
        '{OP_PUSH,   7'd0,   32'h7fffffff,   1'b1, '{32'd0,    ST_OK,    7'd1}},
        '{OP_PUSH,   7'd127, 32'h80000000,   1'b1, '{32'd0,    ST_OK,    7'd2}},
        '{OP_INSERT, 7'd0,   32'hffffffff,   1'b1, '{32'd0,    ST_OK,    7'd3}},
        '{OP_INSERT, 7'd3,   32'd0,          1'b1, '{32'd0,    ST_OK,    7'd4}},
        '{OP_INSERT, 7'd2,   32'h12345678,   1'b1, '{32'd0,    ST_OK,    7'd5}},
        '{OP_READ,   7'd0,   32'd0,          1'b0, '{32'd0,    ST_OK,    7'd0}},
        '{OP_READ,   7'd4,   32'd0,          1'b0, '{32'd0,    ST_OK,    7'd0}},
        '{OP_READ,   7'd5,   32'd0,          1'b1, '{ERR_WORD, ST_RANGE, 7'd5}},
        '{OP_READ,   7'd127, 32'd0,          1'b1, '{ERR_WORD, ST_RANGE, 7'd5}},
        '{OP_WRITE,  7'd4,   32'h5a5a5a5a,   1'b1, '{32'd0,    ST_OK,    7'd5}},
        '{OP_WRITE,  7'd64,  32'ha5a5a5a5,   1'b1, '{ERR_WORD, ST_RANGE, 7'd5}},
        '{OP_INSERT, 7'd6,   32'd1,          1'b1, '{ERR_WORD, ST_RANGE, 7'd5}},
        '{OP_DELETE, 7'd5,   32'd0,          1'b1, '{ERR_WORD, ST_RANGE, 7'd5}},
        '{OP_DELETE, 7'd0,   32'd0,          1'b0, '{32'd0,    ST_OK,    7'd0}},
        '{OP_DELETE, 7'd2,   32'd0,          1'b0, '{32'd0,    ST_OK,    7'd0}},
        '{KIND_SPARE_LO, 7'd64, 32'ha5a5a5a5, 1'b1, '{32'd0, ST_OK, 7'd3}},
        '{OP_POP,    7'd0,   32'd0,          1'b0, '{32'd0,    ST_OK,    7'd0}},
        '{OP_READ,   7'd1,   32'd0,          1'b0, '{32'd0,    ST_OK,    7'd0}}
    };

    indexed_list_buffer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .position    (position),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_value  (read_value),
        .status      (status),
        .fill_level  (fill_level)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // list model: applies one request and returns the result it yields
    function automatic list_result_t apply_list_request(input logic [2:0] op,
                                                        input logic [6:0] pos,
                                                        input logic signed [31:0] word);
        list_result_t r;
        int           i;
        r.value = '0;
        r.st    = ST_OK;
        case (op)
            OP_PUSH:
                if (list_count >= CAP_LEVEL)
                begin
                    r.value = ERR_WORD;
                    r.st    = ST_FULL;
                end
                else
                begin
                    list_words[IDX_W'(list_count)] = word;
                    list_count++;
                end
            OP_POP:
                if (list_count == '0)
                begin
                    r.value = ERR_WORD;
                    r.st    = ST_EMPTY;
                end
                else
                begin
                    list_count--;
                    r.value = list_words[IDX_W'(list_count)];
                end
            OP_READ:
                if (pos >= list_count)
                begin
                    r.value = ERR_WORD;
                    r.st    = ST_RANGE;
                end
                else
                    r.value = list_words[IDX_W'(pos)];
            OP_WRITE:
                if (pos >= list_count)
                begin
                    r.value = ERR_WORD;
                    r.st    = ST_RANGE;
                end
                else
                    list_words[IDX_W'(pos)] = word;
            OP_INSERT:
                // range check wins over the full check
                if (pos > list_count)
                begin
                    r.value = ERR_WORD;
                    r.st    = ST_RANGE;
                end
                else if (list_count >= CAP_LEVEL)
                begin
                    r.value = ERR_WORD;
                    r.st    = ST_FULL;
                end
                else
                begin
                    for (i = int'(list_count); i > int'(pos); i--)
                        list_words[IDX_W'(i)] = list_words[IDX_W'(i-1)];
                    list_words[IDX_W'(pos)] = word;
                    list_count++;
                end
            OP_DELETE:
                if (list_count == '0)
                begin
                    r.value = ERR_WORD;
                    r.st    = ST_EMPTY;
                end
                else if (pos >= list_count)
                begin
                    r.value = ERR_WORD;
                    r.st    = ST_RANGE;
                end
                else
                begin
                    r.value = list_words[IDX_W'(pos)];
                    for (i = int'(pos); i + 1 < int'(list_count); i++)
                        list_words[IDX_W'(i)] = list_words[IDX_W'(i+1)];
                    list_count--;
                end
            default:
                ;
        endcase
        r.level = list_count;
        return r;
    endfunction

    // random word, leaning on the extremes now and then
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'hffffffff;
            3:       return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got %h, expected %h",
                     $time, field, got, want);
    endtask

    // drive one request beat and record its expected result on acceptance
    task automatic send_request(input logic [2:0] op, input logic [6:0] pos,
                                input logic [31:0] word, input bit typed,
                                input list_result_t typed_result);
        list_result_t predicted;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= op;
        position    <= pos;
        write_value <= word;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_list_request(op, pos, word);
        expected_results.push_back(typed ? typed_result : predicted);
        items_sent++;
    endtask

    // result side stalls
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result beat", read_value, 32'd0);
            else
            begin
                oldest_result = expected_results.pop_front();
                if (read_value !== oldest_result.value)
                    report_mismatch("read_value", read_value, oldest_result.value);
                if (status !== oldest_result.st)
                    report_mismatch("status", 32'(status), 32'(oldest_result.st));
                if (fill_level !== oldest_result.level)
                    report_mismatch("fill_level", 32'(fill_level),
                                    32'(oldest_result.level));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** indexed_list_buffer: FAILED **");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int           mode;
        int           extra;
        logic [2:0]   op;
        logic [6:0]   pos;
        list_result_t none_result;
        none_result = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++)
            send_request(directed_rows[r].op, directed_rows[r].pos,
                         directed_rows[r].word, directed_rows[r].typed,
                         directed_rows[r].want);

        // random episodes
        while (items_sent < TOTAL_ITEMS)
        begin
            idle_on = (items_sent < TOTAL_ITEMS - TAIL_ITEMS) &&
                      ($urandom_range(0, 3) != 0);
            mode = $urandom_range(0, 3);
            case (mode)
                // mixed traffic around the current fill
                0:
                    repeat ($urandom_range(20, 60))
                    begin
                        op  = 3'(($urandom_range(0, 15) == 0) ? $urandom_range(6, 7)
                                                              : $urandom_range(0, 5));
                        pos = 7'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, list_count));
                        send_request(op, pos, pick_word(), 1'b0, none_result);
                    end
                // fill to full, then keep knocking
                1:
                begin
                    extra = $urandom_range(1, 4);
                    while (extra > 0)
                    begin
                        if (list_count == CAP_LEVEL)
                            extra--;
                        op  = $urandom_range(0, 1) ? OP_PUSH : OP_INSERT;
                        pos = 7'(($urandom_range(0, 15) == 0) ?
                                 $urandom_range(list_count + 1, 127) :
                                 $urandom_range(0, list_count));
                        send_request(op, pos, pick_word(), 1'b0, none_result);
                    end
                end
                // drain to empty, then poke the empty list
                2:
                begin
                    extra = $urandom_range(1, 4);
                    while (extra > 0)
                    begin
                        op = $urandom_range(0, 1) ? OP_POP : OP_DELETE;
                        if (list_count == '0)
                        begin
                            extra--;
                            if ($urandom_range(0, 1))
                                op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
                            pos = 7'($urandom_range(0, 127));
                        end
                        else
                            pos = 7'(($urandom_range(0, 15) == 0) ?
                                     $urandom_range(list_count, 127) :
                                     $urandom_range(0, list_count - 1));
                        send_request(op, pos, pick_word(), 1'b0, none_result);
                    end
                end
                // read and write burst over the held entries
                default:
                    repeat ($urandom_range(20, 50))
                    begin
                        op  = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
                        pos = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(0, list_count));
                        send_request(op, pos, pick_word(), 1'b0, none_result);
                    end
            endcase
        end
        in_valid <= 1'b0;

        // drain outstanding results
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("** indexed_list_buffer: PASSED **");
        else
            $display("** indexed_list_buffer: FAILED **");
        $finish;
    end

endmodule

/* indexed_list_buffer.f */
sv/ilb_pkg.sv
sv/ilb_cell.sv
sv/indexed_list_buffer.sv
verif/indexed_list_buffer_tb.sv
